// ===== rtl/core/cpts_pkg.sv =====
// Types, constants and microcode ROM of the counter/priority task scheduler.
package cpts_pkg;

  localparam int unsigned TASK_IDX_W = 5;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned PRI_W      = 10;
  localparam int unsigned UPC_W      = 4;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_e;

  // Datapath operation of one microcode step.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DEC,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_SCAN_DRAIN,
    OP_REFILL,
    OP_REFILL_DRAIN,
    OP_COMMIT,
    OP_DONE
  } op_e;

  // Jump condition; the jump is taken when it holds.
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_IS_LOAD,
    C_CUR_IDLE,
    C_DEC_NZ,
    C_PTR_MORE,
    C_FOUND
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [UPC_W-1:0] target;
  } uc_word_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [PRI_W-1:0] pri;
  } slot_entry_t;

  typedef struct packed {
    logic        we_cnt;
    logic        we_pri;
    slot_entry_t data;
  } slot_wr_t;

  // Program labels
  localparam logic [UPC_W-1:0] L_START  = 4'd0;
  localparam logic [UPC_W-1:0] L_SCHED  = 4'd3;
  localparam logic [UPC_W-1:0] L_SCAN   = 4'd4;
  localparam logic [UPC_W-1:0] L_REFILL = 4'd7;
  localparam logic [UPC_W-1:0] L_COMMIT = 4'd9;
  localparam logic [UPC_W-1:0] L_DONE   = 4'd10;
  localparam logic [UPC_W-1:0] L_LOAD   = 4'd11;

  function automatic uc_word_t uc_rom(input logic [UPC_W-1:0] upc);
    uc_word_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: L_DONE};
    case (upc)
      4'd0:  w = '{op: OP_NOP,          cond: C_IS_LOAD,  target: L_LOAD};
      4'd1:  w = '{op: OP_NOP,          cond: C_CUR_IDLE, target: L_SCHED};
      4'd2:  w = '{op: OP_DEC,          cond: C_DEC_NZ,   target: L_DONE};
      4'd3:  w = '{op: OP_SCAN_INIT,    cond: C_NEVER,    target: L_START};
      4'd4:  w = '{op: OP_SCAN,         cond: C_PTR_MORE, target: L_SCAN};
      4'd5:  w = '{op: OP_SCAN_DRAIN,   cond: C_FOUND,    target: L_COMMIT};
      4'd6:  w = '{op: OP_SCAN_INIT,    cond: C_NEVER,    target: L_START};
      4'd7:  w = '{op: OP_REFILL,       cond: C_PTR_MORE, target: L_REFILL};
      4'd8:  w = '{op: OP_REFILL_DRAIN, cond: C_NEVER,    target: L_START};
      4'd9:  w = '{op: OP_COMMIT,       cond: C_NEVER,    target: L_START};
      4'd10: w = '{op: OP_DONE,         cond: C_NEVER,    target: L_START};
      4'd11: w = '{op: OP_LOAD,         cond: C_ALWAYS,   target: L_DONE};
      default: w = '{op: OP_NOP, cond: C_ALWAYS, target: L_DONE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/cpts_in_if.sv =====
// Input channel: load and tick transactions.
interface cpts_in_if;
  import cpts_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [TASK_IDX_W-1:0] task_index;
  logic [CNT_W-1:0]      load_counter;
  logic [PRI_W-1:0]      load_priority;

  modport source (output valid, mode, task_index, load_counter, load_priority,
                  input ready);
  modport sink   (input valid, mode, task_index, load_counter, load_priority,
                  output ready);
endinterface

// ===== rtl/core/cpts_out_if.sv =====
// Output channel: one scheduling result per transaction.
interface cpts_out_if;
  import cpts_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [TASK_IDX_W-1:0] running_task;
  logic [CNT_W-1:0]      running_counter;
  logic                  switched;
  logic                  no_work;

  modport source (output valid, running_task, running_counter, switched, no_work,
                  input ready);
  modport sink   (input valid, running_task, running_counter, switched, no_work,
                  output ready);
endinterface

// ===== rtl/core/cpts_slot_ram.sv =====
// Slot table RAM: counter and priority per slot, one write and one registered read port.
module cpts_slot_ram #(
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                   clk_i,
  input  cpts_pkg::slot_wr_t     wr_i,
  input  logic [AddrW-1:0]       waddr_i,
  input  logic [AddrW-1:0]       raddr_i,
  output cpts_pkg::slot_entry_t  rdata_o
);
  import cpts_pkg::*;

  logic [CNT_W-1:0] cnt_mem [Depth];
  logic [PRI_W-1:0] pri_mem [Depth];
  slot_entry_t      rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we_cnt) begin
      cnt_mem[waddr_i] <= wr_i.data.cnt;
    end
    if (wr_i.we_pri) begin
      pri_mem[waddr_i] <= wr_i.data.pri;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q.cnt <= cnt_mem[raddr_i];
    rdata_q.pri <= pri_mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/counter_priority_task_scheduler_unit.sv =====
// Counter/priority time-slice task scheduler, microcoded top level.
//
//  Channel | Dir | Payload                                          | Transaction
//  in_i    | in  | mode, task_index, load_counter, load_priority    | valid & ready
//  out_o   | out | running_task, running_counter, switched, no_work | valid & ready
//
//  A load, or a tick that only charges a slice, skips the scan. A tick that
//  reschedules scans every slot, and when every counter is spent a second
//  pass refills the counters and picks the best refilled slot. Both loops
//  walk the slot RAM one slot per cycle through its single read port.
//  Reset clears the valid bits, current task and sequencer; RAM contents are
//  only seen through valid bits, so no clearing pass is needed.
//  One transaction is in flight at a time; a new one may be taken while the
//  previous result still waits in the output register. A stalled output holds
//  the sequencer at its final step.
module counter_priority_task_scheduler_unit #(
  parameter int unsigned NUM_TASKS = 32
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  cpts_in_if.sink    in_i,
  cpts_out_if.source out_o
);
  import cpts_pkg::*;

  localparam int unsigned IW = $clog2(NUM_TASKS);

  // Sequencer
  seq_state_e       state_q, state_d;
  logic [UPC_W-1:0] upc_q, upc_d;
  uc_word_t         uw;

  // Latched transaction payload
  logic                  mode_q;
  logic [TASK_IDX_W-1:0] idx_q;
  logic [CNT_W-1:0]      lc_q;
  logic [PRI_W-1:0]      lp_q;

  // Architectural state (slot counters/priorities live in the RAM)
  logic [NUM_TASKS-1:0] valid_q, valid_d;
  logic [IW-1:0]        cur_q, cur_d;
  logic [CNT_W-1:0]     cur_cnt_q, cur_cnt_d;  // shadow of counter[cur]
  logic [IW-1:0]        start_cur_q, start_cur_d;

  // Scan datapath
  logic [IW-1:0]    ptr_q, ptr_d;
  logic [IW-1:0]    cmp_q, cmp_d;     // slot whose RAM data arrives this cycle
  logic             pipe_v_q, pipe_v_d;
  logic [IW-1:0]    best_q, best_d;
  logic [CNT_W-1:0] best_cnt_q, best_cnt_d;
  logic             switched_q, switched_d;
  logic             no_work_q, no_work_d;

  // Output register
  logic                  out_valid_q, out_valid_d;
  logic [TASK_IDX_W-1:0] out_task_q, out_task_d;
  logic [CNT_W-1:0]      out_cnt_q, out_cnt_d;
  logic                  out_sw_q, out_sw_d;
  logic                  out_nw_q, out_nw_d;

  // RAM port
  slot_wr_t    mem_wr;
  logic [IW-1:0] mem_waddr;
  logic [IW-1:0] mem_raddr;
  slot_entry_t mem_rdata;

  // Misc combinational
  logic             in_fire;
  logic             load_ok;
  logic [CNT_W-1:0] dec_val;
  logic [CNT_W-1:0] refill_cnt;
  logic [CNT_W-1:0] cand;
  logic             better;
  logic             cond_ok;
  logic             is_refill;

  cpts_slot_ram #(
    .Depth (NUM_TASKS),
    .AddrW (IW)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .wr_i    (mem_wr),
    .waddr_i (mem_waddr),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign uw       = uc_rom(upc_q);
  assign in_i.ready = (state_q == SEQ_IDLE);
  assign in_fire  = in_i.valid && in_i.ready;

  // Slot 0 is idle; indices beyond the table are dropped.
  assign load_ok  = (idx_q != '0) && (32'(idx_q) < NUM_TASKS);
  assign dec_val  = cur_cnt_q - CNT_W'(cur_cnt_q != '0);
  // (c>>1)+p never exceeds 2046, so 11 bits hold it.
  assign refill_cnt = (mem_rdata.cnt >> 1) + CNT_W'(mem_rdata.pri);
  assign is_refill  = (uw.op == OP_REFILL) || (uw.op == OP_REFILL_DRAIN);
  assign cand       = !valid_q[cmp_q] ? '0 : (is_refill ? refill_cnt : mem_rdata.cnt);
  // Strict compare while walking downwards: higher index keeps a tie.
  assign better     = pipe_v_q && (cand > best_cnt_q);

  always_comb begin
    case (uw.cond)
      C_NEVER:    cond_ok = 1'b0;
      C_ALWAYS:   cond_ok = 1'b1;
      C_IS_LOAD:  cond_ok = !mode_q;
      C_CUR_IDLE: cond_ok = (cur_q == '0);
      C_DEC_NZ:   cond_ok = (dec_val != '0);
      C_PTR_MORE: cond_ok = (ptr_q != IW'(1));
      C_FOUND:    cond_ok = better ? 1'b1 : (best_q != '0);
      default:    cond_ok = 1'b0;
    endcase
  end

  // Next state, datapath and outputs
  always_comb begin
    state_d     = state_q;
    upc_d       = upc_q;
    valid_d     = valid_q;
    cur_d       = cur_q;
    cur_cnt_d   = cur_cnt_q;
    start_cur_d = start_cur_q;
    ptr_d       = ptr_q;
    cmp_d       = cmp_q;
    pipe_v_d    = pipe_v_q;
    best_d      = best_q;
    best_cnt_d  = best_cnt_q;
    switched_d  = switched_q;
    no_work_d   = no_work_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_task_d  = out_task_q;
    out_cnt_d   = out_cnt_q;
    out_sw_d    = out_sw_q;
    out_nw_d    = out_nw_q;
    mem_wr      = '0;
    mem_waddr   = cmp_q;
    mem_raddr   = ptr_q;

    case (state_q)
      SEQ_IDLE: begin
        if (in_fire) begin
          state_d     = SEQ_RUN;
          upc_d       = L_START;
          start_cur_d = cur_q;
          switched_d  = 1'b0;
          no_work_d   = 1'b0;
        end
      end

      SEQ_RUN: begin
        upc_d = cond_ok ? uw.target : upc_q + UPC_W'(1);

        case (uw.op)
          OP_LOAD: begin
            if (load_ok) begin
              mem_wr.we_cnt   = 1'b1;
              mem_wr.we_pri   = 1'b1;
              mem_wr.data.cnt = lc_q;
              mem_wr.data.pri = lp_q;
              mem_waddr       = IW'(idx_q);
              valid_d[IW'(idx_q)] = 1'b1;
              if (32'(idx_q) == 32'(cur_q)) begin
                cur_cnt_d = lc_q;
              end
            end
          end

          OP_DEC: begin
            mem_wr.we_cnt   = 1'b1;
            mem_wr.data.cnt = dec_val;
            mem_waddr       = cur_q;
            cur_cnt_d       = dec_val;
          end

          OP_SCAN_INIT: begin
            ptr_d      = IW'(NUM_TASKS - 1);
            pipe_v_d   = 1'b0;
            best_d     = '0;
            best_cnt_d = '0;
          end

          OP_SCAN, OP_SCAN_DRAIN, OP_REFILL, OP_REFILL_DRAIN: begin
            if (better) begin
              best_d     = cmp_q;
              best_cnt_d = cand;
            end
            if (is_refill && pipe_v_q && valid_q[cmp_q]) begin
              mem_wr.we_cnt   = 1'b1;
              mem_wr.data.cnt = refill_cnt;
              mem_waddr       = cmp_q;
            end
            if ((uw.op == OP_SCAN) || (uw.op == OP_REFILL)) begin
              mem_raddr = ptr_q;
              cmp_d     = ptr_q;
              pipe_v_d  = 1'b1;
              ptr_d     = ptr_q - IW'(1);
            end else begin
              pipe_v_d  = 1'b0;
            end
          end

          OP_COMMIT: begin
            cur_d      = best_q;
            cur_cnt_d  = best_cnt_q;
            no_work_d  = (best_q == '0);
            switched_d = (best_q != start_cur_q);
          end

          OP_DONE: begin
            if (!out_valid_q || out_o.ready) begin
              out_valid_d = 1'b1;
              out_task_d  = TASK_IDX_W'(cur_q);
              out_cnt_d   = cur_cnt_q;
              out_sw_d    = switched_q;
              out_nw_d    = no_work_q;
              state_d     = SEQ_IDLE;
            end else begin
              upc_d = upc_q;
            end
          end

          default: ;
        endcase
      end

      default: state_d = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SEQ_IDLE;
      upc_q       <= L_START;
      valid_q     <= '0;
      cur_q       <= '0;
      cur_cnt_q   <= '0;
      pipe_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      upc_q       <= upc_d;
      valid_q     <= valid_d;
      cur_q       <= cur_d;
      cur_cnt_q   <= cur_cnt_d;
      pipe_v_q    <= pipe_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q <= in_i.mode;
      idx_q  <= in_i.task_index;
      lc_q   <= in_i.load_counter;
      lp_q   <= in_i.load_priority;
    end
    start_cur_q <= start_cur_d;
    ptr_q       <= ptr_d;
    cmp_q       <= cmp_d;
    best_q      <= best_d;
    best_cnt_q  <= best_cnt_d;
    switched_q  <= switched_d;
    no_work_q   <= no_work_d;
    out_task_q  <= out_task_d;
    out_cnt_q   <= out_cnt_d;
    out_sw_q    <= out_sw_d;
    out_nw_q    <= out_nw_d;
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.running_task    = out_task_q;
  assign out_o.running_counter = out_cnt_q;
  assign out_o.switched        = out_sw_q;
  assign out_o.no_work         = out_nw_q;

  // A running task always comes from a loaded slot.
  a_cur_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_q != '0) |-> valid_q[cur_q])
    else $error("current task slot not valid");

  // The idle task never carries slices.
  a_idle_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_q == '0) |-> (cur_cnt_q == '0))
    else $error("idle task with nonzero counter");

  // No-work results always report the idle task.
  a_no_work_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_nw_q) |-> (out_task_q == '0))
    else $error("no_work with a task selected");

  // RAM is written only while a transaction is being worked on.
  a_wr_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_wr.we_cnt || mem_wr.we_pri) |-> (state_q == SEQ_RUN))
    else $error("slot RAM written while idle");

  // Scan loops never address the idle slot.
  a_ptr_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == SEQ_RUN) && ((uw.op == OP_SCAN) || (uw.op == OP_REFILL)))
      |-> (ptr_q != '0))
    else $error("scan pointer reached the idle slot");

endmodule

// ===== sim/cpts_sched_checker.sv =====
// Scoreboard for the task scheduler: predicts each result and compares it with the DUT.
module cpts_sched_checker #(
  parameter int unsigned NUM_TASKS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cpts_in_if          in_mon_i,
  cpts_out_if         out_mon_i,
  output int unsigned pending_o,
  output int unsigned mismatch_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import cpts_pkg::*;

  typedef struct packed {
    logic [TASK_IDX_W-1:0] running_task;
    logic [CNT_W-1:0]      running_counter;
    logic                  switched;
    logic                  no_work;
  } sched_result_t;

  // Shadow copy of the slot tables and the current task.
  logic [CNT_W-1:0]      slice_tbl [NUM_TASKS];
  logic [PRI_W-1:0]      prio_tbl  [NUM_TASKS];
  logic                  slot_live [NUM_TASKS];
  logic [TASK_IDX_W-1:0] running_slot;

  sched_result_t expected_q [$];
  sched_result_t oldest;
  int unsigned   mismatch_count;

  assign mismatch_count_o = mismatch_count;

  task automatic report_mismatch(input string field, input logic [31:0] got_v,
                                 input logic [31:0] exp_v);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got_v, exp_v);
    mismatch_count++;
  endtask

  // Highest nonzero counter among live slots, higher index wins ties; 0 if none.
  function automatic logic [TASK_IDX_W-1:0] best_slot();
    logic [TASK_IDX_W-1:0] best;
    logic [CNT_W-1:0]      best_cnt;
    best     = '0;
    best_cnt = '0;
    for (int i = NUM_TASKS - 1; i >= 1; i--) begin
      if (slot_live[i] && slice_tbl[i] > best_cnt) begin
        best_cnt = slice_tbl[i];
        best     = TASK_IDX_W'(i);
      end
    end
    return best;
  endfunction

  // Returns 1 when nothing is runnable even after a refill.
  function automatic logic reschedule();
    logic [TASK_IDX_W-1:0] nxt;
    nxt = best_slot();
    if (nxt == '0) begin
      for (int i = 1; i < NUM_TASKS; i++)
        if (slot_live[i]) slice_tbl[i] = (slice_tbl[i] >> 1) + CNT_W'(prio_tbl[i]);
      nxt = best_slot();
    end
    running_slot = nxt;
    return nxt == '0;
  endfunction

  function automatic sched_result_t advance_scheduler(input logic tick,
                                                      input logic [TASK_IDX_W-1:0] idx,
                                                      input logic [CNT_W-1:0] cnt,
                                                      input logic [PRI_W-1:0] pri);
    sched_result_t         res;
    logic [TASK_IDX_W-1:0] prev;
    logic                  starved;
    prev    = running_slot;
    starved = 1'b0;
    if (!tick) begin
      if (idx != '0 && idx < NUM_TASKS) begin
        slice_tbl[idx] = cnt;
        prio_tbl[idx]  = pri;
        slot_live[idx] = 1'b1;
      end
    end else if (running_slot == '0 || running_slot >= NUM_TASKS) begin
      starved = reschedule();
    end else begin
      if (slice_tbl[running_slot] != '0)
        slice_tbl[running_slot] = slice_tbl[running_slot] - 1'b1;
      if (slice_tbl[running_slot] == '0) starved = reschedule();
    end
    res.running_task    = running_slot;
    res.running_counter = (running_slot < NUM_TASKS) ? slice_tbl[running_slot] : '0;
    res.switched        = running_slot != prev;
    res.no_work         = starved;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_TASKS; s++) begin
        slice_tbl[s] = '0;
        prio_tbl[s]  = '0;
        slot_live[s] = 1'b0;
      end
      running_slot   = '0;
      mismatch_count = 0;
      expected_q.delete();
      pending_o <= 0;
    end else begin
      // results first: anything leaving now belongs to an older transaction
      if (out_mon_i.valid === 1'b1 && out_mon_i.ready === 1'b1) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", out_mon_i.running_task, '0);
        end else begin
          oldest = expected_q.pop_front();
          if (out_mon_i.running_task !== oldest.running_task)
            report_mismatch("running_task", out_mon_i.running_task, oldest.running_task);
          if (out_mon_i.running_counter !== oldest.running_counter)
            report_mismatch("running_counter", out_mon_i.running_counter,
                            oldest.running_counter);
          if (out_mon_i.switched !== oldest.switched)
            report_mismatch("switched", out_mon_i.switched, oldest.switched);
          if (out_mon_i.no_work !== oldest.no_work)
            report_mismatch("no_work", out_mon_i.no_work, oldest.no_work);
        end
      end
      // mode bit set means a timer tick
      if (in_mon_i.valid === 1'b1 && in_mon_i.ready === 1'b1)
        expected_q.push_back(advance_scheduler(in_mon_i.mode, in_mon_i.task_index,
                                               in_mon_i.load_counter,
                                               in_mon_i.load_priority));
      pending_o <= expected_q.size();
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the task scheduler: clock, reset, stimulus, receiver stalls and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cpts_pkg::*;

  localparam int unsigned NUM_TASKS    = 32;
  localparam logic        MODE_LOAD    = 1'b0;
  localparam logic        MODE_TICK    = 1'b1;
  localparam int unsigned RANDOM_ITEMS = 1500;
  // Worst transaction is a scan, refill and rescan of every slot.
  localparam int unsigned DRAIN_CYCLES = 2 * NUM_TASKS + 16;
  // Slowest honest run is roughly 1700 transactions, each a full scan and refill
  // plus the longest sender gap and receiver stall; the watchdog sits well above that.
  localparam int unsigned CYCLE_LIMIT  = 1_500_000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned cycle_count = 0;
  int unsigned pending_results;
  int unsigned mismatch_total;
  bit          calm_sender = 1'b0;

  cpts_in_if  in_if ();
  cpts_out_if out_if ();

  counter_priority_task_scheduler_unit #(
    .NUM_TASKS (NUM_TASKS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  cpts_sched_checker #(
    .NUM_TASKS (NUM_TASKS)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_mon_i         (in_if),
    .out_mon_i        (out_if),
    .pending_o        (pending_results),
    .mismatch_count_o (mismatch_total)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("counter_priority_task_scheduler_unit regression: fail");
      $finish;
    end
  end

  // Idle length after a transaction or a burst of ready: mostly none or a
  // short one, now and then a long one. Calm stretches give back-to-back
  // traffic.
  function automatic int unsigned gap_cycles(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Presents one transaction, holds it until accepted, then maybe idles.
  // valid is only dropped when a gap follows, so back-to-back transactions
  // never see a low/high pair in the same time step.
  task automatic send_item(input logic mode, input logic [TASK_IDX_W-1:0] idx,
                           input logic [CNT_W-1:0] cnt, input logic [PRI_W-1:0] pri);
    int unsigned gap;
    in_if.valid         <= 1'b1;
    in_if.mode          <= mode;
    in_if.task_index    <= idx;
    in_if.load_counter  <= cnt;
    in_if.load_priority <= pri;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    gap = gap_cycles(calm_sender);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_load(input logic [TASK_IDX_W-1:0] idx, input logic [CNT_W-1:0] cnt,
                           input logic [PRI_W-1:0] pri);
    send_item(MODE_LOAD, idx, cnt, pri);
  endtask

  // Payload fields are don't-care on a tick, so they are randomised.
  task automatic send_tick();
    send_item(MODE_TICK, TASK_IDX_W'($urandom), CNT_W'($urandom), PRI_W'($urandom));
  endtask

  // Load to a real slot; counters are mostly short so that slices run out and
  // the scan/refill paths are exercised, with the odd full-range value.
  task automatic send_random_load();
    int unsigned r;
    logic [CNT_W-1:0] cnt;
    logic [PRI_W-1:0] pri;
    r = $urandom_range(0, 99);
    if (r < 75)      cnt = CNT_W'($urandom_range(0, 6));
    else if (r < 92) cnt = CNT_W'($urandom_range(7, 40));
    else             cnt = CNT_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 70) pri = PRI_W'($urandom_range(0, 4));
    else        pri = PRI_W'($urandom);
    send_load(TASK_IDX_W'($urandom_range(1, NUM_TASKS - 1)), cnt, pri);
  endtask

  // Sender pauses until the scoreboard has nothing outstanding.
  task automatic hold_until_results_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
  endtask

  // Receiver: ready bursts of random length, mostly short, occasionally long
  // stretches with no back-pressure; stalls come from the same gap profile.
  initial begin : receiver
    int unsigned stall;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      out_if.ready <= 1'b1;
      repeat (($urandom_range(0, 19) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 6))
        @(posedge clk_i);
      stall = gap_cycles(1'b0);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int unsigned accepted;
    int unsigned kind;
    bit          mid_drained;
    accepted    = 0;
    mid_drained = 1'b0;
    rst_ni      = 1'b0;
    in_if.valid         <= 1'b0;
    in_if.mode          <= MODE_LOAD;
    in_if.task_index    <= '0;
    in_if.load_counter  <= '0;
    in_if.load_priority <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part ----
    // Tick with an empty table: nothing runnable, idle stays, no_work raised.
    send_tick();
    // Load to the idle slot is dropped, so the next tick still finds no work.
    send_load('0, '1, '1);
    send_tick();
    // A live slot with zero counter and zero priority: refill yields nothing.
    send_load(TASK_IDX_W'(5), '0, '0);
    send_tick();
    // Two slots with equal counters: the higher index must win the scan.
    send_load(TASK_IDX_W'(3), CNT_W'(2), PRI_W'(1));
    send_load(TASK_IDX_W'(9), CNT_W'(2), PRI_W'(2));
    send_tick();
    send_tick();
    // Slot 9 runs out, slot 3 takes over.
    send_tick();
    // Overwrite the running task's counter; the effect shows on the next tick,
    // which spends it and forces a refill (3 -> 1, 9 -> 2, 5 -> 0).
    send_load(TASK_IDX_W'(3), CNT_W'(1), PRI_W'(1));
    send_tick();
    // Top slot with the widest counter and priority.
    send_load(TASK_IDX_W'(NUM_TASKS - 1), '1, '1);
    send_tick();
    send_tick();
    send_tick();
    // Cut the top slot short, then exhaust everything so refill uses the
    // maximum priority.
    send_load(TASK_IDX_W'(NUM_TASKS - 1), CNT_W'(1), '1);
    send_tick();
    send_tick();
    // Alternating bit patterns on the payload fields.
    send_load(TASK_IDX_W'(17), CNT_W'(11'h555), PRI_W'(10'h2AA));
    send_load(TASK_IDX_W'(18), CNT_W'(11'h2AA), PRI_W'(10'h155));
    // Running task reloaded with a zero counter: no decrement, straight rescan.
    send_load(TASK_IDX_W'(NUM_TASKS - 1), '0, '0);
    send_tick();
    hold_until_results_drained();

    // ---- random part ----
    while (accepted < RANDOM_ITEMS) begin
      calm_sender = ($urandom_range(0, 5) == 0);
      kind        = $urandom_range(0, 99);
      if (kind < 3) begin
        // Wipe every slot to zero counter and priority: following ticks must
        // report no work until something is loaded again.
        for (int s = 1; s < NUM_TASKS; s++) begin
          send_load(TASK_IDX_W'(s), '0, '0);
          accepted++;
        end
        repeat ($urandom_range(1, 3)) begin
          send_tick();
          accepted++;
        end
      end else if (kind < 8) begin
        // Noise: a load to the idle slot (ignored, not counted) then a lone tick.
        send_load('0, CNT_W'($urandom), PRI_W'($urandom));
        send_tick();
        accepted++;
      end else begin
        // Typical traffic: a few loads, then a run of ticks.
        repeat ($urandom_range(0, 4)) begin
          send_random_load();
          accepted++;
        end
        repeat ($urandom_range(1, 8)) begin
          send_tick();
          accepted++;
        end
      end
      if (!mid_drained && accepted >= RANDOM_ITEMS / 2) begin
        hold_until_results_drained();
        mid_drained = 1'b1;
      end
    end

    // ---- wind-down ----
    hold_until_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_total == 0 && pending_results == 0)
      $display("counter_priority_task_scheduler_unit regression: pass");
    else
      $display("counter_priority_task_scheduler_unit regression: fail");
    $finish;
  end

endmodule
